// ===== hw/rtl/pcxrle_pkg.sv =====
`default_nettype none

package pcxrle_pkg;

   localparam int CFG_W   = 13;
   localparam int H_W     = 16;
   localparam int POS_W   = 15;
   localparam int CNT_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int PIX_W   = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PLANE_LINE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THREE_PLANES         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH          = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT         = 2'd3;

   localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
   localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [CNT_W-1:0]  count;
   } pcxrle_cmd_type;

   // Clamped configuration as seen by the expansion side.
   typedef struct packed {
      logic [POS_W-1:0] bpl;
      logic [POS_W-1:0] bpl2;
      logic [POS_W-1:0] len;
      logic [CFG_W-1:0] width;
      logic [H_W-1:0]   height;
      logic             three;
   } pcxrle_cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pcxrle_front.sv =====
`default_nettype none

module pcxrle_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pcxrle_pkg::BYTE_W-1:0] req_stream_byte,
   input  wire logic                          q_full,
   output logic                               q_push,
   output pcxrle_pkg::pcxrle_cmd_type         q_cmd
);
   import pcxrle_pkg::*;

   logic             accept;
   logic             awaiting_ff, awaiting_in;
   logic [CNT_W-1:0] pending_ff, pending_in;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      awaiting_in = awaiting_ff;
      pending_in  = pending_ff;
      q_push      = 1'b0;
      q_cmd.data  = req_stream_byte;
      q_cmd.count = CNT_W'(1);
      if (accept) begin
         if (awaiting_ff) begin
            awaiting_in = 1'b0;
            pending_in  = '0;
            q_cmd.count = pending_ff;
            // A zero-length run produces nothing, so it never reaches the queue.
            q_push      = (pending_ff != '0);
         end else if (req_stream_byte >= RUN_MARK) begin
            awaiting_in = 1'b1;
            pending_in  = CNT_W'(req_stream_byte & RUN_MASK);
         end else begin
            q_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         awaiting_ff <= awaiting_in;
         pending_ff  <= pending_in;
      end
   end

   a_run_value_clears: assert property (@(posedge clock) disable iff (reset)
      accept && awaiting_ff |=> !awaiting_ff)
      else $error("run value byte did not end the run header");

endmodule

`default_nettype wire

// ===== hw/rtl/pcxrle_queue.sv =====
`default_nettype none

module pcxrle_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire pcxrle_pkg::pcxrle_cmd_type  push_cmd,
   output logic                             full,
   output logic                             not_empty,
   input  wire logic                        pop,
   output pcxrle_pkg::pcxrle_cmd_type       pop_cmd
);
   import pcxrle_pkg::*;

   pcxrle_cmd_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcxrle_back.sv =====
`default_nettype none

module pcxrle_back #(
   parameter int MAX_LINE_PIXELS = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pcxrle_pkg::pcxrle_cfg_type   cfg,
   input  wire logic                         q_not_empty,
   input  wire pcxrle_pkg::pcxrle_cmd_type   q_cmd,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [pcxrle_pkg::PIX_W-1:0]      rsp_pixel_value,
   output logic                              rsp_last_of_burst,
   output logic                              rsp_image_done
);
   import pcxrle_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LINE_PIXELS);
   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;

   function automatic logic [H_W-1:0] next_line(input logic [H_W-1:0] v,
                                                input logic [H_W-1:0] h);
      logic [H_W:0] s;
      s = {1'b0, v} + (H_W+1)'(1);
      return (s >= {1'b0, h}) ? '0 : s[H_W-1:0];
   endfunction

   // Line stores for the red and green planes.
   logic [BYTE_W-1:0] red_mem [MAX_LINE_PIXELS];
   logic [BYTE_W-1:0] grn_mem [MAX_LINE_PIXELS];
   logic [BYTE_W-1:0] rd_red_ff, rd_grn_ff;

   logic              cmd_active_ff;
   logic [BYTE_W-1:0] cmd_byte_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [POS_W-1:0]  lp_ff, lp_in;
   logic [H_W-1:0]    ln_ff, ln_in;

   logic              hold_valid_ff;
   logic [BYTE_W-1:0] hold_byte_ff;
   logic              hold_three_ff;
   logic              hold_done_ff;

   logic              out_valid_ff;
   logic [PIX_W-1:0]  out_pix_ff;
   logic              out_last_ff;
   logic              out_done_ff;

   logic              pre_close, line_end, keep, emit, done_flag, place_go;
   logic              out_free, push_out, push_last;
   logic [1:0]        plane;
   logic [POS_W-1:0]  lp_e, lp_plus, base, x_pos;
   logic [CFG_W-1:0]  x;
   logic [ADDR_W-1:0] addr;
   logic [H_W-1:0]    ln_mid;
   logic [PIX_W-1:0]  hold_pix;

   always_comb begin
      pre_close = (lp_ff >= cfg.len);
      lp_e      = pre_close ? '0 : lp_ff;
      ln_mid    = pre_close ? next_line(ln_ff, cfg.height) : ln_ff;
      if (lp_e < cfg.bpl) begin
         plane = PLANE_RED;
         base  = '0;
      end else if (lp_e < cfg.bpl2) begin
         plane = PLANE_GREEN;
         base  = cfg.bpl;
      end else begin
         plane = PLANE_BLUE;
         base  = cfg.bpl2;
      end
      x_pos     = lp_e - base;
      x         = x_pos[CFG_W-1:0];
      addr      = ADDR_W'(x);
      keep      = (x < cfg.width);
      emit      = keep && (!cfg.three || plane == PLANE_BLUE);
      done_flag = (ln_mid >= cfg.height - H_W'(1)) && (x == cfg.width - CFG_W'(1));
      lp_plus   = lp_e + POS_W'(1);
      line_end  = (lp_plus >= cfg.len);
      lp_in     = line_end ? '0 : lp_plus;
      ln_in     = line_end ? next_line(ln_mid, cfg.height) : ln_mid;
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   // A new pixel may only replace a held one if the held one can leave.
   assign place_go = cmd_active_ff && (!emit || !hold_valid_ff || out_free);
   assign push_last = !cmd_active_ff && hold_valid_ff && out_free;
   assign push_out  = (place_go && emit && hold_valid_ff) || push_last;
   assign q_pop     = !cmd_active_ff && q_not_empty && (!hold_valid_ff || out_free);

   assign hold_pix = hold_three_ff ? {hold_byte_ff, rd_grn_ff, rd_red_ff}
                                   : {{(PIX_W-BYTE_W){1'b0}}, hold_byte_ff};

   always_ff @(posedge clock) begin
      if (place_go && keep && cfg.three && plane == PLANE_RED) begin
         red_mem[addr] <= cmd_byte_ff;
      end
      if (place_go && keep && cfg.three && plane == PLANE_GREEN) begin
         grn_mem[addr] <= cmd_byte_ff;
      end
      if (place_go && emit) begin
         rd_red_ff <= red_mem[addr];
         rd_grn_ff <= grn_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_byte_ff <= q_cmd.data;
      end
      if (place_go && emit) begin
         hold_byte_ff  <= cmd_byte_ff;
         hold_three_ff <= cfg.three;
         hold_done_ff  <= done_flag;
      end
      if (push_out) begin
         out_pix_ff  <= hold_pix;
         out_last_ff <= push_last;
         out_done_ff <= hold_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_active_ff <= 1'b0;
         cnt_ff        <= '0;
         lp_ff         <= '0;
         ln_ff         <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            cmd_active_ff <= 1'b1;
            cnt_ff        <= q_cmd.count;
         end else if (place_go) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            // A run that reaches the end of the line drops its remainder.
            if (cnt_ff == CNT_W'(1) || line_end) begin
               cmd_active_ff <= 1'b0;
            end
         end
         if (place_go) begin
            lp_ff <= lp_in;
            ln_ff <= ln_in;
         end
         if (place_go && emit) begin
            hold_valid_ff <= 1'b1;
         end else if (push_last) begin
            hold_valid_ff <= 1'b0;
         end
         if (push_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_value   = out_pix_ff;
   assign rsp_last_of_burst = out_last_ff;
   assign rsp_image_done    = out_done_ff;

   a_active_has_count: assert property (@(posedge clock) disable iff (reset)
      cmd_active_ff |-> cnt_ff != '0)
      else $error("expansion active with an empty count");

   a_hold_drains: assert property (@(posedge clock) disable iff (reset)
      !cmd_active_ff && hold_valid_ff && out_free |=> !hold_valid_ff)
      else $error("held pixel not released at end of request");

   a_position_in_line: assert property (@(posedge clock) disable iff (reset)
      place_go ##1 $stable(cfg.len) |-> lp_ff < cfg.len)
      else $error("line position left the line after a placement");

endmodule

`default_nettype wire

// ===== hw/rtl/pcx_rle_scanline_decoder_top.sv =====
`default_nettype none

// Channel   Ports                                 Direction   Handshake
// request   req_valid, req_stall, req_stream_byte in          valid / stall
// response  rsp_valid, rsp_stall, rsp_pixel_value, out        valid / stall
//           rsp_last_of_burst, rsp_image_done
// csr       csr_valid, csr_ready, csr_index,      in          valid / ready
//           csr_data
//
// A literal byte is first loaded from the command queue and then placed. A run value
// is loaded the same way and then repeated, the expansion unit placing one byte per
// cycle unless response stalls hold it. Run headers never enter the command queue.
// Reset is synchronous; the line stores need no clearing after reset.
// Response stalls hold the expander while a held pixel cannot move to the output register;
// the two-entry queue keeps taking requests meanwhile until it fills.

module pcx_rle_scanline_decoder_top #(
   parameter int MAX_LINE_PIXELS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pcxrle_pkg::BYTE_W-1:0]     req_stream_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [pcxrle_pkg::PIX_W-1:0]           rsp_pixel_value,
   output logic                                   rsp_last_of_burst,
   output logic                                   rsp_image_done,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pcxrle_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0] csr_data
);
   import pcxrle_pkg::*;

   logic [CFG_W-1:0] bpl_ff, width_ff;
   logic             three_ff;
   logic [H_W-1:0]   height_ff;
   pcxrle_cfg_type   eff_ff, eff_in;
   logic [CFG_W-1:0] bpl_e, width_1;

   pcxrle_cmd_type   push_cmd, pop_cmd;
   logic             q_push, q_pop, q_full, q_not_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff    <= CFG_W'(1);
         three_ff  <= 1'b0;
         width_ff  <= CFG_W'(1);
         height_ff <= H_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BYTES_PER_PLANE_LINE: bpl_ff    <= csr_data[CFG_W-1:0];
            CSR_THREE_PLANES:         three_ff  <= csr_data[0];
            CSR_IMAGE_WIDTH:          width_ff  <= csr_data[CFG_W-1:0];
            CSR_IMAGE_HEIGHT:         height_ff <= csr_data[H_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the raw settings once so the expander sees legal values only.
   always_comb begin
      if (bpl_ff == '0) begin
         bpl_e = CFG_W'(1);
      end else if ({{(32-CFG_W){1'b0}}, bpl_ff} > 32'(MAX_LINE_PIXELS)) begin
         bpl_e = CFG_W'(MAX_LINE_PIXELS);
      end else begin
         bpl_e = bpl_ff;
      end
      width_1       = (width_ff == '0) ? CFG_W'(1) : width_ff;
      eff_in.width  = (width_1 > bpl_e) ? bpl_e : width_1;
      eff_in.height = (height_ff == '0) ? H_W'(1) : height_ff;
      eff_in.three  = three_ff;
      eff_in.bpl    = POS_W'(bpl_e);
      eff_in.bpl2   = POS_W'(bpl_e) << 1;
      eff_in.len    = three_ff ? (POS_W'(bpl_e) << 1) + POS_W'(bpl_e) : POS_W'(bpl_e);
   end

   always_ff @(posedge clock) begin
      eff_ff <= eff_in;
   end

   pcxrle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   pcxrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_cmd   (pop_cmd)
   );

   pcxrle_back #(
      .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (eff_ff),
      .q_not_empty       (q_not_empty),
      .q_cmd             (pop_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_image_done    (rsp_image_done)
   );

endmodule

`default_nettype wire

// ===== dv/tb_pcx_rle_scanline_decoder_top.sv =====
`timescale 1ns / 100ps

module tb_pcx_rle_scanline_decoder_top;
   import pcxrle_pkg::*;

   localparam int LINE_PIXELS = 4096;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
      logic             done;
   } pixel_rec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_stream_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_value;
   logic                  rsp_last_of_burst;
   logic                  rsp_image_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int error_count = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Decoder image of the block: register copies and stream state.
   logic [CFG_W-1:0] fmt_bpl;
   logic             fmt_three;
   logic [CFG_W-1:0] fmt_width;
   logic [H_W-1:0]   fmt_height;
   bit               awaiting_run;
   logic [CNT_W-1:0] pending_len;
   int               line_pos;
   int               line_num;
   logic [7:0]       red_line [0:LINE_PIXELS-1];
   logic [7:0]       green_line [0:LINE_PIXELS-1];

   pixel_rec_type expected_pixels[$];

   pcx_rle_scanline_decoder_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_image_done    (rsp_image_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin : pixel_check
      pixel_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t: unexpected pixel, expected none actual %h last %b done %b", $time,
                     rsp_pixel_value, rsp_last_of_burst, rsp_image_done);
         end else begin
            want = expected_pixels.pop_front();
            if (want.pixel !== rsp_pixel_value || want.last !== rsp_last_of_burst ||
                want.done !== rsp_image_done) begin
               error_count++;
               $display("%0t: pixel mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                        want.pixel, want.last, want.done,
                        rsp_pixel_value, rsp_last_of_burst, rsp_image_done);
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("tb_pcx_rle_scanline_decoder_top: errors");
      $finish;
   end

   function automatic int eff_bpl();
      if (fmt_bpl == 0) return 1;
      if (fmt_bpl > LINE_PIXELS) return LINE_PIXELS;
      return fmt_bpl;
   endfunction

   function automatic int line_len();
      return eff_bpl() * (fmt_three ? 3 : 1);
   endfunction

   function automatic void close_line();
      int h;
      h = (fmt_height == 0) ? 1 : fmt_height;
      line_pos = 0;
      line_num++;
      if (line_num >= h) line_num = 0;
   endfunction

   // Places one decoded byte in the scanline; returns 1 when it ends the line.
   function automatic bit place_byte(input logic [7:0] b, inout int n);
      int bpl, len, w, h, p, x;
      bit emit;
      logic [PIX_W-1:0] v;
      pixel_rec_type rec;
      bpl = eff_bpl();
      len = line_len();
      w = (fmt_width == 0) ? 1 : fmt_width;
      if (w > bpl) w = bpl;
      h = (fmt_height == 0) ? 1 : fmt_height;
      if (line_pos >= len) close_line();
      p = line_pos / bpl;
      x = line_pos % bpl;
      emit = 1'b0;
      v = '0;
      if (x < w) begin
         if (!fmt_three) begin
            emit = 1'b1;
            v = {16'h0000, b};
         end else if (p == 0) begin
            red_line[x] = b;
         end else if (p == 1) begin
            green_line[x] = b;
         end else begin
            emit = 1'b1;
            v = {b, green_line[x], red_line[x]};
         end
         if (emit) begin
            rec.pixel = v;
            rec.last = 1'b0;
            rec.done = (line_num >= h - 1) && (x == w - 1);
            expected_pixels.push_back(rec);
            n++;
         end
      end
      line_pos++;
      if (line_pos >= len) begin
         close_line();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      int n, cnt;
      n = 0;
      if (awaiting_run) begin
         cnt = pending_len;
         awaiting_run = 1'b0;
         pending_len = '0;
         for (int i = 0; i < cnt; i++) begin
            if (place_byte(b, n)) break;
         end
      end else if (b >= RUN_MARK) begin
         awaiting_run = 1'b1;
         pending_len = b[CNT_W-1:0] & RUN_MASK[CNT_W-1:0];
      end else begin
         void'(place_byte(b, n));
      end
      if (n > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b);
   endtask

   task automatic send_literal();
      send_byte(8'($urandom_range(0, 8'hBF)));
   endtask

   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // Runs that place no pixel can still be expanding once the queue is empty.
   task automatic settle();
      drain_pixels();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BYTES_PER_PLANE_LINE: fmt_bpl = val[CFG_W-1:0];
         CSR_THREE_PLANES:         fmt_three = val[0];
         CSR_IMAGE_WIDTH:          fmt_width = val[CFG_W-1:0];
         CSR_IMAGE_HEIGHT:         fmt_height = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Feeds bytes until the stream sits at the start of a scanline.
   task automatic finish_line();
      int len, cnt;
      while (awaiting_run || line_pos != 0) begin
         len = line_len();
         if (awaiting_run || line_pos >= len || len - line_pos < 2) begin
            send_literal();
         end else begin
            cnt = (len - line_pos > 63) ? 63 : len - line_pos;
            send_byte(RUN_MARK | cnt[7:0]);
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Upper data bits beyond each register's width carry random junk.
   task automatic set_format(input int bpl, input bit three, input int width, input int height);
      logic [CSR_DATA_W-1:0] d;
      finish_line();
      settle();
      d = CSR_DATA_W'($urandom);
      d[CFG_W-1:0] = bpl[CFG_W-1:0];
      write_csr(CSR_BYTES_PER_PLANE_LINE, d);
      d = CSR_DATA_W'($urandom);
      d[0] = three;
      write_csr(CSR_THREE_PLANES, d);
      d = CSR_DATA_W'($urandom);
      d[CFG_W-1:0] = width[CFG_W-1:0];
      write_csr(CSR_IMAGE_WIDTH, d);
      write_csr(CSR_IMAGE_HEIGHT, height[CSR_DATA_W-1:0]);
   endtask

   task automatic random_format();
      int bpl;
      bpl = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(0, 80);
      set_format(bpl, 1'($urandom_range(0, 1)), $urandom_range(0, bpl + 1),
                 $urandom_range(0, 5));
   endtask

   task automatic test_literal_extremes();
      set_format(4, 1'b0, 4, 2);
      send_byte(8'h00);
      send_byte(8'hBF);
      send_byte(8'h55);
      send_byte(8'h2A);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h3C);
      send_byte(8'h00);
   endtask

   task automatic test_run_forms();
      set_format(4, 1'b0, 4, 2);
      send_byte(RUN_MARK);
      send_byte(8'h33);
      send_byte(8'hC3);
      send_byte(8'hFF);
      // A long run overruns the line end and its tail is thrown away.
      send_byte(8'hFF);
      send_byte(8'h12);
      send_byte(8'hC1);
      send_byte(8'hC0);
   endtask

   task automatic test_padding();
      set_format(6, 1'b0, 3, 1);
      for (int i = 0; i < 6; i++) send_literal();
      send_byte(8'hC8);
      send_byte(8'h77);
   endtask

   task automatic test_three_planes();
      set_format(3, 1'b1, 2, 2);
      send_byte(8'hC3);
      send_byte(8'h10);
      send_byte(8'h20);
      send_byte(8'h21);
      send_byte(8'h22);
      send_byte(8'h30);
      send_byte(8'h31);
      send_byte(8'h32);
      for (int i = 0; i < 9; i++) send_literal();
   endtask

   task automatic test_register_limits();
      set_format(0, 1'b0, 0, 0);
      for (int i = 0; i < 3; i++) send_literal();
      set_format(8191, 1'b1, 8191, 65535);
      send_literal();
      // Dropping to one short plane mid-line makes the next byte close the long line.
      settle();
      write_csr(CSR_THREE_PLANES, 16'd0);
      write_csr(CSR_BYTES_PER_PLANE_LINE, 16'd0);
      write_csr(CSR_IMAGE_WIDTH, 16'd5);
      write_csr(CSR_IMAGE_HEIGHT, 16'd0);
      for (int i = 0; i < 3; i++) send_literal();
   endtask

   // Shrinking the line while mid-line makes the next byte close the old line first.
   task automatic test_midline_reconfig();
      set_format(8, 1'b0, 8, 3);
      for (int i = 0; i < 5; i++) send_literal();
      settle();
      write_csr(CSR_BYTES_PER_PLANE_LINE, 16'd3);
      write_csr(CSR_IMAGE_WIDTH, 16'd3);
      for (int i = 0; i < 4; i++) send_literal();
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n_items);
      int sent, r;
      sender_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int blk = 0; blk < 3; blk++) begin
         random_format();
         sent = 0;
         while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               send_literal();
               sent++;
            end else if (r < 85) begin
               send_byte(RUN_MARK |
                         8'((r < 70) ? $urandom_range(1, 8) : $urandom_range(9, 63)));
               send_byte(8'($urandom_range(0, 255)));
               sent += 2;
            end else if (r < 92) begin
               send_byte(RUN_MARK);
               send_byte(8'($urandom_range(0, 255)));
               sent += 2;
            end else if (r < 97) begin
               send_byte(8'hFF);
               send_byte(8'($urandom_range(0, 255)));
               sent += 2;
            end else begin
               drain_pixels();
            end
         end
      end
   endtask

   initial begin
      fmt_bpl = 1;
      fmt_three = 1'b0;
      fmt_width = 1;
      fmt_height = 1;
      awaiting_run = 1'b0;
      pending_len = '0;
      line_pos = 0;
      line_num = 0;
      for (int i = 0; i < LINE_PIXELS; i++) begin
         red_line[i] = 8'h00;
         green_line[i] = 8'h00;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_literal_extremes();
      test_run_forms();
      test_padding();
      test_three_planes();
      test_register_limits();
      test_midline_reconfig();
      test_random_stream(0, 0, 32);
      test_random_stream(62, 0, 32);
      test_random_stream(0, 62, 32);
      test_random_stream(33, 33, 32);

      drain_pixels();
      sender_idle_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         error_count++;
         $display("%0t: %0d pixels never arrived, expected %h actual none", $time,
                  expected_pixels.size(), expected_pixels[0].pixel);
      end
      if (error_count == 0) begin
         $display("tb_pcx_rle_scanline_decoder_top: clean");
      end else begin
         $display("tb_pcx_rle_scanline_decoder_top: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pcxrle_pkg.sv
hw/rtl/pcxrle_front.sv
hw/rtl/pcxrle_queue.sv
hw/rtl/pcxrle_back.sv
hw/rtl/pcx_rle_scanline_decoder_top.sv
dv/tb_pcx_rle_scanline_decoder_top.sv
